[rtl/sine_weighted_halving_fir_defines.svh]
`ifndef SINE_WEIGHTED_HALVING_FIR_DEFINES_SVH
`define SINE_WEIGHTED_HALVING_FIR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SWHF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SWHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swhf_pkg.sv]
package swhf_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int OUT_W           = 18;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;

  localparam int TAPS_DEF           = 16;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 15;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;       // capture new sample
    logic mul;        // multiply one tap, advance line
    logic first;      // first tap: line takes 3x
    logic use_x;      // last tap: multiply the new sample
    logic acc_en;     // accumulate registered product
    logic acc_first;  // accumulator takes product without halving
    logic out_load;   // write result register
  } swhf_cmd_t;

  typedef struct packed {
    logic out_free;
  } swhf_status_t;

  // sin(x), x and result in Q30, Taylor series through the x^15 term.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Q30 angle to coefficient with frac fraction bits, round half up, capped at 1.0.
  function automatic logic [63:0] coef_from_theta(input logic [63:0] theta, input int frac);
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] cap;
    s   = sine_q30(theta);
    c   = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    cap = 64'd1 << frac;
    if (c > cap) begin
      c = cap;
    end
    return c;
  endfunction

endpackage

[rtl/swhf_ctrl.sv]
module swhf_ctrl import swhf_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  swhf_status_t            status,
  output swhf_cmd_t               cmd,
  output logic [$clog2(TAPS)-1:0] tap_idx
);

  localparam int IDX_W = $clog2(TAPS);
  localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(TAPS - 1);
  localparam logic [IDX_W-1:0] TAP_ONE  = IDX_W'(1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mul       = 1'b1;
        cmd.first     = (cnt_r == '0);
        cmd.use_x     = (cnt_r == LAST_TAP);
        cmd.acc_en    = (cnt_r != '0);
        cmd.acc_first = (cnt_r == TAP_ONE);
        cnt_nxt       = cnt_r + TAP_ONE;
        if (cnt_r == LAST_TAP) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.acc_en = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign tap_idx = cnt_r;

endmodule

[rtl/swhf_datapath.sv]
module swhf_datapath import swhf_pkg::*; #(
  parameter int TAPS           = TAPS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swhf_cmd_t               cmd,
  input  logic [$clog2(TAPS)-1:0] tap_idx,
  input  logic [SAMPLE_W-1:0]     sample,
  output swhf_status_t            status,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  localparam int RAW_W  = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int ENT_W  = SAMPLE_BITS + 2;
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = ENT_W + COEF_W;
  localparam int ACC_W  = PROD_W;
  localparam int SUM_W  = ACC_W + 1;
  localparam int Y_W    = ACC_W - COEF_FRAC_BITS;
  localparam int CMP_W  = (Y_W > OUT_W) ? Y_W : OUT_W;
  localparam logic signed [CMP_W-1:0] OUT_MAX = CMP_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [CMP_W-1:0] OUT_MIN = CMP_W'(-(64'sd1 <<< (OUT_W - 1)));

  // coefficient ROM
  logic [COEF_W-1:0] coef_tab [TAPS];

  for (genvar g = 0; g < TAPS; g++) begin : g_coef
    localparam int          M     = (g < TAPS - 1 - g) ? g : TAPS - 1 - g;
    localparam logic [63:0] THETA =
      (64'(2 * M) * PI_Q30 + 64'(TAPS - 1)) / 64'(2 * (TAPS - 1));
    localparam logic [COEF_W-1:0] COEF = COEF_W'(coef_from_theta(THETA, COEF_FRAC_BITS));
    assign coef_tab[g] = COEF;
  end

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [ENT_W-1:0]       line_r [TAPS-1];
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic [OUT_W-1:0]              out_data_r, out_data_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [RAW_W-1:0]        raw;
  logic signed [ENT_W-1:0] x_ext;
  logic signed [ENT_W-1:0] x3;
  logic signed [ENT_W-1:0] operand;
  logic signed [SUM_W-1:0] sum;
  logic signed [Y_W-1:0]   y;
  logic signed [CMP_W-1:0] y_ext;

  assign raw     = RAW_W'(sample);
  assign x_ext   = ENT_W'(x_r);
  assign x3      = x_ext + (x_ext <<< 1);
  assign operand = cmd.use_x ? x_ext : line_r[0];
  assign prod_nxt = $signed(PROD_W'(operand)) * $signed(PROD_W'({1'b0, coef_tab[tap_idx]}));

  assign sum     = SUM_W'(acc_r) + SUM_W'(prod_r);
  assign acc_nxt = cmd.acc_first ? prod_r : sum[SUM_W-1:1];

  assign y     = acc_r[ACC_W-1:COEF_FRAC_BITS];
  assign y_ext = CMP_W'(y);

  always_comb begin
    priority if (y_ext > OUT_MAX) begin
      out_data_nxt = OUT_MAX[OUT_W-1:0];
    end else if (y_ext < OUT_MIN) begin
      out_data_nxt = OUT_MIN[OUT_W-1:0];
    end else begin
      out_data_nxt = y_ext[OUT_W-1:0];
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul) begin
        for (int i = 0; i < TAPS - 2; i++) begin
          line_r[i] <= line_r[i+1];
        end
        line_r[TAPS-2] <= cmd.first ? x3 : line_r[0];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= raw[SAMPLE_BITS-1:0];
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign status.out_free = ~out_valid_r | out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = OUT_TDATA_W'(out_data_r);

endmodule

[rtl/sine_weighted_halving_fir.sv]
// Sine-weighted halving FIR low-pass. One signed sample in, one filtered
// value out per transfer. A single multiply-accumulate unit walks the TAPS
// coefficients (sin(k*pi/(TAPS-1)) in unsigned fixed point) one tap per
// cycle, halving the running sum as each tap after the first is added; the
// delay line keeps three times each past sample and is cleared by reset.
// An item goes through capture, the MAC loop, product drain and result
// write, which waits until the output register is free.
// One item is processed at a time; a new sample is taken as soon as the
// previous result has been written to the output register, even while that
// result waits for out_tready.
module sine_weighted_halving_fir import swhf_pkg::*; #(
  parameter int TAPS           = TAPS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [17:0] filtered, [23:18] zero
);

  swhf_cmd_t              cmd;
  swhf_status_t           status;
  logic [$clog2(TAPS)-1:0] tap_idx;

  swhf_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .tap_idx   (tap_idx)
  );

  swhf_datapath #(
    .TAPS           (TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .tap_idx    (tap_idx),
    .sample     (in_tdata[SAMPLE_W-1:0]),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/swhf_checker.sv]
`include "sine_weighted_halving_fir_defines.svh"

module swhf_checker import swhf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `SWHF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `SWHF_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")
  `SWHF_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:OUT_W] == '0, "tdata pad bits set")
  `SWHF_ASSERT_IMPL(a_no_early_out, clk, rst_n, $rose(out_tvalid), !$past(in_tvalid && in_tready), "result right after input")

endmodule

bind sine_weighted_halving_fir swhf_checker u_swhf_checker (.*);
